[rtl/core/gcdrb_pkg.sv]
package gcdrb_pkg;

    localparam int MAX_CHUNKS  = 64;
    localparam int MAX_DOMAINS = 64;
    localparam int MAX_RANKS   = 64;

    localparam int ELEM_W = 32;
    localparam int REQ_W  = 7;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int LOAD_W = 38;
    localparam int CFG_W  = 7;

    localparam logic [REQ_W-1:0] FREE_CODE = 7'h7F;

    localparam logic [0:0] REG_TARGET = 1'b0;
    localparam logic [0:0] REG_RANKS  = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLEAR,
        OP_SUM_LD,
        OP_SUM_WR,
        OP_FILL_INIT,
        OP_FILL,
        OP_AS_CHK,
        OP_AS_SCAN,
        OP_AS_WR,
        OP_RK_LD,
        OP_RK_WR,
        OP_PL_INIT,
        OP_PL_SCAN,
        OP_PL_CHK,
        OP_RS_SCAN,
        OP_PL_WR,
        OP_EM_LOAD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] d;
        logic             lastk;
    } cmd_t;

    typedef struct packed {
        logic             ch_free;
        logic             rk_fixed;
        logic             found;
        logic [IDX_W-1:0] nr_last;
    } sts_t;

    // Saturate a register value to 1 .. 64.
    function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = 7'd1;
        end
        else if (v > 7'd64)
        begin
            r = 7'd64;
        end
        return r;
    endfunction

endpackage

[rtl/core/gcdrb_in_if.sv]
interface gcdrb_in_if;
    logic                           valid;
    logic                           ready;
    logic [gcdrb_pkg::ELEM_W-1:0]   element_count;
    logic signed [gcdrb_pkg::REQ_W-1:0] wanted_domain;
    logic signed [gcdrb_pkg::REQ_W-1:0] wanted_rank;
    logic                           last_chunk;

    modport source(output valid, element_count, wanted_domain, wanted_rank, last_chunk,
                   input ready);
    modport sink(input valid, element_count, wanted_domain, wanted_rank, last_chunk,
                 output ready);
endinterface

[rtl/core/gcdrb_out_if.sv]
interface gcdrb_out_if;
    logic                        valid;
    logic                        ready;
    logic [gcdrb_pkg::IDX_W-1:0] chunk_index;
    logic [gcdrb_pkg::IDX_W-1:0] assigned_domain;
    logic [gcdrb_pkg::IDX_W-1:0] assigned_rank;
    logic                        over_target;
    logic                        last_result;

    modport source(output valid, chunk_index, assigned_domain, assigned_rank, over_target,
                   last_result, input ready);
    modport sink(input valid, chunk_index, assigned_domain, assigned_rank, over_target,
                 last_result, output ready);
endinterface

[rtl/core/gcdrb_datapath.sv]
module gcdrb_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gcdrb_pkg::cmd_t                  cmd,
    output gcdrb_pkg::sts_t                  sts,
    input  logic [gcdrb_pkg::ELEM_W-1:0]     element_count,
    input  logic signed [gcdrb_pkg::REQ_W-1:0] wanted_domain,
    input  logic signed [gcdrb_pkg::REQ_W-1:0] wanted_rank,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [gcdrb_pkg::CFG_W-1:0]      cfg_data,
    output logic [gcdrb_pkg::IDX_W-1:0]      chunk_index,
    output logic [gcdrb_pkg::IDX_W-1:0]      assigned_domain,
    output logic [gcdrb_pkg::IDX_W-1:0]      assigned_rank,
    output logic                             over_target,
    output logic                             last_result
);

    typedef struct packed {
        logic [gcdrb_pkg::ELEM_W-1:0] el;
        logic [gcdrb_pkg::REQ_W-1:0]  dom;
        logic [gcdrb_pkg::REQ_W-1:0]  rnk;
    } chunk_t;

    typedef logic [gcdrb_pkg::LOAD_W-1:0] load_t;
    typedef logic [gcdrb_pkg::IDX_W-1:0]  idx_t;

    chunk_t ch_mem    [gcdrb_pkg::MAX_CHUNKS];
    idx_t   dom_mem   [gcdrb_pkg::MAX_CHUNKS];
    idx_t   rk_mem    [gcdrb_pkg::MAX_CHUNKS];
    load_t  dl_mem    [gcdrb_pkg::MAX_DOMAINS];
    load_t  rl_mem    [gcdrb_pkg::MAX_RANKS];
    idx_t   drank_mem [gcdrb_pkg::MAX_DOMAINS];

    logic [gcdrb_pkg::CFG_W-1:0]       tgt_reg;
    logic [gcdrb_pkg::CFG_W-1:0]       nr_reg;
    logic [gcdrb_pkg::CNT_W-1:0]       named_reg;
    logic [gcdrb_pkg::CNT_W-1:0]       want_reg;
    logic                              over_reg;
    logic [gcdrb_pkg::MAX_DOMAINS-1:0] in_use_reg;
    logic [gcdrb_pkg::MAX_DOMAINS-1:0] need_reg;
    logic [gcdrb_pkg::MAX_DOMAINS-1:0] placed_reg;
    logic [gcdrb_pkg::MAX_DOMAINS-1:0] dl_vld_reg;
    logic [gcdrb_pkg::MAX_RANKS-1:0]   rl_vld_reg;
    logic                              found_reg;
    logic                              rfound_reg;
    gcdrb_pkg::op_t                    op_q_reg;
    idx_t                              d_q_reg;

    chunk_t ch_q_reg;
    idx_t   dm_q_reg;
    idx_t   rk_q_reg;
    load_t  dl_q_reg;
    logic   dlv_q_reg;
    load_t  rl_q_reg;
    logic   rlv_q_reg;
    idx_t   drank_q_reg;
    logic   pl_q_reg;
    idx_t   best_d_reg;
    load_t  best_load_reg;
    idx_t   rbest_reg;
    load_t  rbest_load_reg;

    logic [gcdrb_pkg::CFG_W-1:0] tgt_c;
    logic [gcdrb_pkg::CFG_W-1:0] nr_c;
    idx_t                        dl_ra;
    idx_t                        rl_ra;
    idx_t                        dsum;
    idx_t                        rfix;
    load_t                       dl_rd;
    load_t                       rl_rd;
    load_t                       el_ext;
    logic                        rk_fixed;
    logic                        as_take;
    logic                        pl_take;
    logic                        rs_take;
    logic [gcdrb_pkg::REQ_W-1:0] dom_code;
    logic [gcdrb_pkg::REQ_W-1:0] rnk_code;

    always_comb
    begin
        tgt_c    = gcdrb_pkg::clamp_cfg(tgt_reg);
        nr_c     = gcdrb_pkg::clamp_cfg(nr_reg);
        dsum     = ch_q_reg.dom[gcdrb_pkg::IDX_W-1:0];
        rfix     = ch_q_reg.rnk[gcdrb_pkg::IDX_W-1:0];
        dl_ra    = (cmd.op == gcdrb_pkg::OP_SUM_LD) ? dsum : cmd.d;
        rl_ra    = (cmd.op == gcdrb_pkg::OP_RK_LD) ? rfix : cmd.d;
        dl_rd    = dlv_q_reg ? dl_q_reg : '0;
        rl_rd    = rlv_q_reg ? rl_q_reg : '0;
        el_ext   = load_t'(ch_q_reg.el);
        rk_fixed = !ch_q_reg.rnk[gcdrb_pkg::REQ_W-1] && (ch_q_reg.rnk < nr_c);
        as_take  = (op_q_reg == gcdrb_pkg::OP_AS_SCAN) && in_use_reg[d_q_reg]
                   && (!found_reg || (dl_rd < best_load_reg));
        pl_take  = (op_q_reg == gcdrb_pkg::OP_PL_SCAN) && need_reg[d_q_reg]
                   && (!found_reg || (dl_rd > best_load_reg));
        rs_take  = (op_q_reg == gcdrb_pkg::OP_RS_SCAN)
                   && (!rfound_reg || (rl_rd < rbest_load_reg));
        dom_code = wanted_domain[gcdrb_pkg::REQ_W-1] ? gcdrb_pkg::FREE_CODE
                                                      : wanted_domain;
        rnk_code = wanted_rank[gcdrb_pkg::REQ_W-1] ? gcdrb_pkg::FREE_CODE : wanted_rank;

        sts.ch_free  = ch_q_reg.dom[gcdrb_pkg::REQ_W-1];
        sts.rk_fixed = rk_fixed;
        sts.found    = found_reg;
        sts.nr_last  = idx_t'(nr_c - 7'd1);
    end

    // Control state: config, per-batch flags, search flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg    <= 7'd1;
            nr_reg     <= 7'd1;
            named_reg  <= '0;
            want_reg   <= '0;
            over_reg   <= 1'b0;
            in_use_reg <= '0;
            need_reg   <= '0;
            placed_reg <= '0;
            dl_vld_reg <= '0;
            rl_vld_reg <= '0;
            found_reg  <= 1'b0;
            rfound_reg <= 1'b0;
            op_q_reg   <= gcdrb_pkg::OP_NOP;
            d_q_reg    <= '0;
        end
        else
        begin
            op_q_reg <= cmd.op;
            d_q_reg  <= cmd.d;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gcdrb_pkg::REG_TARGET: tgt_reg <= cfg_data;
                    gcdrb_pkg::REG_RANKS:  nr_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (as_take || pl_take)
            begin
                found_reg <= 1'b1;
            end
            if (rs_take)
            begin
                rfound_reg <= 1'b1;
            end
            case (cmd.op)
                gcdrb_pkg::OP_CLEAR:
                begin
                    named_reg  <= '0;
                    over_reg   <= 1'b0;
                    in_use_reg <= '0;
                    need_reg   <= '0;
                    placed_reg <= '0;
                    dl_vld_reg <= '0;
                    rl_vld_reg <= '0;
                end
                gcdrb_pkg::OP_SUM_WR:
                begin
                    if (!in_use_reg[dsum])
                    begin
                        named_reg <= named_reg + 7'd1;
                    end
                    in_use_reg[dsum] <= 1'b1;
                    dl_vld_reg[dsum] <= 1'b1;
                end
                gcdrb_pkg::OP_FILL_INIT:
                begin
                    over_reg <= named_reg > tgt_c;
                    want_reg <= (named_reg > tgt_c) ? '0 : tgt_c - named_reg;
                end
                gcdrb_pkg::OP_FILL:
                begin
                    if ((want_reg != '0) && !in_use_reg[cmd.d])
                    begin
                        in_use_reg[cmd.d] <= 1'b1;
                        want_reg          <= want_reg - 7'd1;
                    end
                end
                gcdrb_pkg::OP_AS_CHK:  found_reg <= 1'b0;
                gcdrb_pkg::OP_AS_WR:   dl_vld_reg[best_d_reg] <= 1'b1;
                gcdrb_pkg::OP_RK_LD:
                begin
                    if (!rk_fixed)
                    begin
                        need_reg[dm_q_reg] <= 1'b1;
                    end
                end
                gcdrb_pkg::OP_RK_WR:   rl_vld_reg[rfix] <= 1'b1;
                gcdrb_pkg::OP_PL_INIT: found_reg <= 1'b0;
                gcdrb_pkg::OP_PL_CHK:
                begin
                    if (found_reg)
                    begin
                        need_reg[best_d_reg]   <= 1'b0;
                        placed_reg[best_d_reg] <= 1'b1;
                    end
                    rfound_reg <= 1'b0;
                end
                gcdrb_pkg::OP_PL_WR:   rl_vld_reg[rbest_reg] <= 1'b1;
                default: ;
            endcase
        end
    end

    // Memories, read registers, search winners and the result register.
    always_ff @(posedge clk)
    begin
        ch_q_reg    <= ch_mem[cmd.k];
        dm_q_reg    <= dom_mem[cmd.k];
        rk_q_reg    <= rk_mem[cmd.k];
        dl_q_reg    <= dl_mem[dl_ra];
        dlv_q_reg   <= dl_vld_reg[dl_ra];
        rl_q_reg    <= rl_mem[rl_ra];
        rlv_q_reg   <= rl_vld_reg[rl_ra];
        drank_q_reg <= drank_mem[dm_q_reg];
        pl_q_reg    <= placed_reg[dm_q_reg];

        if (as_take || pl_take)
        begin
            best_d_reg    <= d_q_reg;
            best_load_reg <= dl_rd;
        end
        if (rs_take)
        begin
            rbest_reg      <= d_q_reg;
            rbest_load_reg <= rl_rd;
        end

        case (cmd.op)
            gcdrb_pkg::OP_LOAD:
            begin
                ch_mem[cmd.k] <= '{el: element_count, dom: dom_code, rnk: rnk_code};
            end
            gcdrb_pkg::OP_SUM_WR: dl_mem[dsum] <= dl_rd + el_ext;
            gcdrb_pkg::OP_AS_CHK:
            begin
                if (!ch_q_reg.dom[gcdrb_pkg::REQ_W-1])
                begin
                    dom_mem[cmd.k] <= dsum;
                end
            end
            gcdrb_pkg::OP_AS_WR:
            begin
                dl_mem[best_d_reg] <= best_load_reg + el_ext;
                dom_mem[cmd.k]     <= best_d_reg;
            end
            gcdrb_pkg::OP_RK_LD:
            begin
                if (!rk_fixed)
                begin
                    rk_mem[cmd.k] <= '0;
                end
            end
            gcdrb_pkg::OP_RK_WR:
            begin
                rl_mem[rfix]  <= rl_rd + el_ext;
                rk_mem[cmd.k] <= rfix;
            end
            gcdrb_pkg::OP_PL_WR:
            begin
                rl_mem[rbest_reg]     <= rbest_load_reg + best_load_reg;
                drank_mem[best_d_reg] <= rbest_reg;
            end
            gcdrb_pkg::OP_EM_LOAD:
            begin
                chunk_index     <= cmd.k;
                assigned_domain <= dm_q_reg;
                assigned_rank   <= pl_q_reg ? drank_q_reg : rk_q_reg;
                over_target     <= over_reg;
                last_result     <= cmd.lastk;
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/gcdrb_ctrl.sv]
module gcdrb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            chunk_valid,
    input  logic            chunk_last,
    output logic            chunk_ready,
    output logic            result_valid,
    input  logic            result_ready,
    input  gcdrb_pkg::sts_t sts,
    output gcdrb_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR,
        S_SUM_RD, S_SUM_LD, S_SUM_WR,
        S_FILL_INIT, S_FILL,
        S_AS_RD, S_AS_CHK, S_AS_SCAN, S_AS_DRN, S_AS_WR,
        S_RK_RD, S_RK_LD, S_RK_WR,
        S_PL_INIT, S_PL_SCAN, S_PL_DRN, S_PL_CHK, S_RS_SCAN, S_RS_DRN, S_PL_WR,
        S_EM_RD, S_EM_LOOK, S_EM_LOAD, S_EM_WAIT
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [gcdrb_pkg::IDX_W-1:0]     k_reg;
    logic [gcdrb_pkg::IDX_W-1:0]     k_next;
    logic [gcdrb_pkg::IDX_W-1:0]     d_reg;
    logic [gcdrb_pkg::IDX_W-1:0]     d_next;
    logic [gcdrb_pkg::IDX_W-1:0]     cnt_reg;
    logic [gcdrb_pkg::IDX_W-1:0]     cnt_next;
    logic [gcdrb_pkg::CNT_W-1:0]     n_reg;
    logic [gcdrb_pkg::CNT_W-1:0]     n_next;
    logic                            klast;

    localparam logic [gcdrb_pkg::IDX_W-1:0] IDX_TOP = gcdrb_pkg::IDX_W'(gcdrb_pkg::MAX_CHUNKS - 1);
    localparam logic [gcdrb_pkg::IDX_W-1:0] DOM_TOP = gcdrb_pkg::IDX_W'(gcdrb_pkg::MAX_DOMAINS - 1);

    always_comb
    begin
        klast        = ({1'b0, k_reg} + 7'd1) == n_reg;
        state_next   = state_reg;
        k_next       = k_reg;
        d_next       = d_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        cmd.op       = gcdrb_pkg::OP_NOP;
        cmd.k        = (state_reg == S_IDLE) ? cnt_reg : k_reg;
        cmd.d        = d_reg;
        cmd.lastk    = klast;
        chunk_ready  = (state_reg == S_IDLE);
        result_valid = (state_reg == S_EM_WAIT);

        unique case (state_reg)
            S_IDLE:
            begin
                if (chunk_valid)
                begin
                    cmd.op = gcdrb_pkg::OP_LOAD;
                    if (chunk_last || (cnt_reg == IDX_TOP))
                    begin
                        n_next     = {1'b0, cnt_reg} + 7'd1;
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.op     = gcdrb_pkg::OP_CLEAR;
                k_next     = '0;
                state_next = S_SUM_RD;
            end
            S_SUM_RD: state_next = S_SUM_LD;
            S_SUM_LD:
            begin
                cmd.op = gcdrb_pkg::OP_SUM_LD;
                if (!sts.ch_free)
                begin
                    state_next = S_SUM_WR;
                end
                else if (klast)
                begin
                    state_next = S_FILL_INIT;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_SUM_RD;
                end
            end
            S_SUM_WR:
            begin
                cmd.op = gcdrb_pkg::OP_SUM_WR;
                if (klast)
                begin
                    state_next = S_FILL_INIT;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_SUM_RD;
                end
            end
            S_FILL_INIT:
            begin
                cmd.op     = gcdrb_pkg::OP_FILL_INIT;
                d_next     = '0;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.op = gcdrb_pkg::OP_FILL;
                if (d_reg == DOM_TOP)
                begin
                    k_next     = '0;
                    state_next = S_AS_RD;
                end
                else
                begin
                    d_next = d_reg + 6'd1;
                end
            end
            S_AS_RD: state_next = S_AS_CHK;
            S_AS_CHK:
            begin
                cmd.op = gcdrb_pkg::OP_AS_CHK;
                if (sts.ch_free)
                begin
                    d_next     = '0;
                    state_next = S_AS_SCAN;
                end
                else if (klast)
                begin
                    k_next     = '0;
                    state_next = S_RK_RD;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_AS_RD;
                end
            end
            S_AS_SCAN:
            begin
                cmd.op = gcdrb_pkg::OP_AS_SCAN;
                if (d_reg == DOM_TOP)
                begin
                    state_next = S_AS_DRN;
                end
                else
                begin
                    d_next = d_reg + 6'd1;
                end
            end
            S_AS_DRN: state_next = S_AS_WR;
            S_AS_WR:
            begin
                cmd.op = gcdrb_pkg::OP_AS_WR;
                if (klast)
                begin
                    k_next     = '0;
                    state_next = S_RK_RD;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_AS_RD;
                end
            end
            S_RK_RD: state_next = S_RK_LD;
            S_RK_LD:
            begin
                cmd.op = gcdrb_pkg::OP_RK_LD;
                if (sts.rk_fixed)
                begin
                    state_next = S_RK_WR;
                end
                else if (klast)
                begin
                    state_next = S_PL_INIT;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_RK_RD;
                end
            end
            S_RK_WR:
            begin
                cmd.op = gcdrb_pkg::OP_RK_WR;
                if (klast)
                begin
                    state_next = S_PL_INIT;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_RK_RD;
                end
            end
            S_PL_INIT:
            begin
                cmd.op     = gcdrb_pkg::OP_PL_INIT;
                d_next     = DOM_TOP;
                state_next = S_PL_SCAN;
            end
            S_PL_SCAN:
            begin
                // descending scan so equal loads resolve to the higher id
                cmd.op = gcdrb_pkg::OP_PL_SCAN;
                if (d_reg == '0)
                begin
                    state_next = S_PL_DRN;
                end
                else
                begin
                    d_next = d_reg - 6'd1;
                end
            end
            S_PL_DRN: state_next = S_PL_CHK;
            S_PL_CHK:
            begin
                cmd.op = gcdrb_pkg::OP_PL_CHK;
                if (sts.found)
                begin
                    d_next     = '0;
                    state_next = S_RS_SCAN;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end
            end
            S_RS_SCAN:
            begin
                cmd.op = gcdrb_pkg::OP_RS_SCAN;
                if (d_reg == sts.nr_last)
                begin
                    state_next = S_RS_DRN;
                end
                else
                begin
                    d_next = d_reg + 6'd1;
                end
            end
            S_RS_DRN: state_next = S_PL_WR;
            S_PL_WR:
            begin
                cmd.op     = gcdrb_pkg::OP_PL_WR;
                state_next = S_PL_INIT;
            end
            S_EM_RD:   state_next = S_EM_LOOK;
            S_EM_LOOK: state_next = S_EM_LOAD;
            S_EM_LOAD:
            begin
                cmd.op     = gcdrb_pkg::OP_EM_LOAD;
                state_next = S_EM_WAIT;
            end
            S_EM_WAIT:
            begin
                if (result_ready)
                begin
                    if (klast)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            d_reg     <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            d_reg     <= d_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
        end
    end

endmodule

[rtl/core/greedy_chunk_domain_rank_balancer_core.sv]
// Chunk balancer: load a batch of up to 64 chunks, one item per cycle, ending with
// last_chunk or the 64th chunk. The block then stops taking items, places free chunks
// on the least-loaded domain and free domains on the least-loaded rank, and returns one
// result per chunk in load order. Each result is read, looked up and loaded into the
// result register, then held until the sink is ready. Each free chunk costs a full
// 64-entry scan of the domain-load memory, one entry per cycle, and each placed domain
// one domain scan plus one rank-load scan.
module greedy_chunk_domain_rank_balancer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    gcdrb_in_if.sink                    chunk_ch,
    gcdrb_out_if.source                 result_ch,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [gcdrb_pkg::CFG_W-1:0] cfg_data
);

    gcdrb_pkg::cmd_t cmd;
    gcdrb_pkg::sts_t sts;

    gcdrb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_valid (chunk_ch.valid),
        .chunk_last  (chunk_ch.last_chunk),
        .chunk_ready (chunk_ch.ready),
        .result_valid(result_ch.valid),
        .result_ready(result_ch.ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    gcdrb_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .element_count  (chunk_ch.element_count),
        .wanted_domain  (chunk_ch.wanted_domain),
        .wanted_rank    (chunk_ch.wanted_rank),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .chunk_index    (result_ch.chunk_index),
        .assigned_domain(result_ch.assigned_domain),
        .assigned_rank  (result_ch.assigned_rank),
        .over_target    (result_ch.over_target),
        .last_result    (result_ch.last_result)
    );

endmodule

[rtl/core/gcdrb_checker.sv]
module gcdrb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        chunk_valid,
    input logic                        chunk_ready,
    input logic                        chunk_last,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic                        result_last,
    input logic [gcdrb_pkg::IDX_W-1:0] result_index,
    input logic [gcdrb_pkg::IDX_W-1:0] result_domain,
    input logic [gcdrb_pkg::IDX_W-1:0] result_rank
);

    // loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(chunk_ready && result_valid))
        else $error("input ready while a result is offered");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_index)
            && $stable(result_domain) && $stable(result_rank) && $stable(result_last))
        else $error("stalled result changed");

    a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_valid && chunk_ready && chunk_last |=> !chunk_ready)
        else $error("input still ready after the final chunk");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result_last |=> chunk_ready)
        else $error("not idle after the final result");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_last |=> !chunk_ready)
        else $error("idle before the batch was emitted");

endmodule

bind greedy_chunk_domain_rank_balancer_core gcdrb_checker u_gcdrb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .chunk_valid  (chunk_ch.valid),
    .chunk_ready  (chunk_ch.ready),
    .chunk_last   (chunk_ch.last_chunk),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_last  (result_ch.last_result),
    .result_index (result_ch.chunk_index),
    .result_domain(result_ch.assigned_domain),
    .result_rank  (result_ch.assigned_rank)
);

[tb/sv/greedy_chunk_domain_rank_balancer_core_tb.sv]
module greedy_chunk_domain_rank_balancer_core_tb;

    typedef struct {
        logic [gcdrb_pkg::ELEM_W-1:0]       elems;
        logic signed [gcdrb_pkg::REQ_W-1:0] dom;
        logic signed [gcdrb_pkg::REQ_W-1:0] rnk;
        logic                               last;
    } chunk_t;

    typedef struct {
        logic [gcdrb_pkg::IDX_W-1:0] idx;
        logic [gcdrb_pkg::IDX_W-1:0] dom;
        logic [gcdrb_pkg::IDX_W-1:0] rnk;
        logic                        over;
        logic                        last;
    } placement_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [gcdrb_pkg::CFG_W-1:0] cfg_data;

    gcdrb_in_if  chunk_ch();
    gcdrb_out_if result_ch();

    greedy_chunk_domain_rank_balancer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chunk_ch  (chunk_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    chunk_t     chunk_q[$];
    placement_t placement_q[$];

    // batch held by the predictor
    logic [gcdrb_pkg::ELEM_W-1:0] held_elems[gcdrb_pkg::MAX_CHUNKS];
    int                           held_dom[gcdrb_pkg::MAX_CHUNKS];
    int                           held_rank[gcdrb_pkg::MAX_CHUNKS];
    int                           held_count;

    logic [gcdrb_pkg::CFG_W-1:0] shadow_target;
    logic [gcdrb_pkg::CFG_W-1:0] shadow_ranks;

    int  errors;
    int  send_gap;
    int  ready_gap;
    bit  quiet;
    bit  in_taken;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int sat64(input logic [gcdrb_pkg::CFG_W-1:0] v);
        int r;
        r = int'(v);
        if (r < 1)
        begin
            r = 1;
        end
        if (r > 64)
        begin
            r = 64;
        end
        return r;
    endfunction

    // Work out the placement of the held batch and queue one result per chunk.
    function automatic void place_batch();
        int n;
        int tgt;
        int nr;
        logic [63:0] dload[gcdrb_pkg::MAX_DOMAINS];
        logic [63:0] rload[gcdrb_pkg::MAX_RANKS];
        bit inuse[gcdrb_pkg::MAX_DOMAINS];
        bit need[gcdrb_pkg::MAX_DOMAINS];
        int dom[gcdrb_pkg::MAX_CHUNKS];
        int rnk[gcdrb_pkg::MAX_CHUNKS];
        int named;
        int want;
        int best;
        int pick;
        bit found;
        bit over;
        placement_t p;
        n = held_count;
        tgt = sat64(shadow_target);
        nr = sat64(shadow_ranks);
        named = 0;
        for (int d = 0; d < gcdrb_pkg::MAX_DOMAINS; d++)
        begin
            dload[d] = 0;
            rload[d] = 0;
            inuse[d] = 0;
            need[d] = 0;
        end
        for (int k = 0; k < n; k++)
        begin
            if (held_dom[k] >= 0)
            begin
                if (!inuse[held_dom[k]])
                begin
                    inuse[held_dom[k]] = 1;
                    named++;
                end
                dload[held_dom[k]] += held_elems[k];
            end
        end
        over = named > tgt;
        if (!over)
        begin
            want = tgt - named;
            for (int d = 0; d < gcdrb_pkg::MAX_DOMAINS && want > 0; d++)
            begin
                if (!inuse[d])
                begin
                    inuse[d] = 1;
                    want--;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            if (held_dom[k] >= 0)
            begin
                dom[k] = held_dom[k];
            end
            else
            begin
                found = 0;
                best = 0;
                for (int d = 0; d < gcdrb_pkg::MAX_DOMAINS; d++)
                begin
                    if (inuse[d] && (!found || dload[d] < dload[best]))
                    begin
                        best = d;
                        found = 1;
                    end
                end
                inuse[best] = 1;
                dom[k] = best;
                dload[best] += held_elems[k];
            end
        end
        for (int k = 0; k < n; k++)
        begin
            if (held_rank[k] >= 0 && held_rank[k] < nr)
            begin
                rnk[k] = held_rank[k];
                rload[held_rank[k]] += held_elems[k];
            end
            else
            begin
                rnk[k] = 0;
                need[dom[k]] = 1;
            end
        end
        // largest domain first, descending id on equal loads
        forever
        begin
            found = 0;
            pick = 0;
            for (int d = gcdrb_pkg::MAX_DOMAINS - 1; d >= 0; d--)
            begin
                if (need[d] && (!found || dload[d] > dload[pick]))
                begin
                    pick = d;
                    found = 1;
                end
            end
            if (!found)
            begin
                break;
            end
            need[pick] = 0;
            best = 0;
            for (int r = 1; r < nr; r++)
            begin
                if (rload[r] < rload[best])
                begin
                    best = r;
                end
            end
            rload[best] += dload[pick];
            for (int k = 0; k < n; k++)
            begin
                if (dom[k] == pick)
                begin
                    rnk[k] = best;
                end
            end
        end
        for (int k = 0; k < n; k++)
        begin
            p.idx = k[gcdrb_pkg::IDX_W-1:0];
            p.dom = dom[k][gcdrb_pkg::IDX_W-1:0];
            p.rnk = rnk[k][gcdrb_pkg::IDX_W-1:0];
            p.over = over;
            p.last = (k + 1 == n);
            placement_q.insert(placement_q.size(), p);
        end
        held_count = 0;
    endfunction

    task automatic report(input string what, input int want, input int got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        placement_t e;
        in_taken <= rst_n && chunk_ch.valid && chunk_ch.ready;
        if (rst_n && chunk_ch.valid && chunk_ch.ready)
        begin
            held_elems[held_count] = chunk_ch.element_count;
            held_dom[held_count] = (chunk_ch.wanted_domain < 0) ? -1
                                   : int'(chunk_ch.wanted_domain);
            held_rank[held_count] = (chunk_ch.wanted_rank < 0) ? -1
                                    : int'(chunk_ch.wanted_rank);
            held_count++;
            if (chunk_ch.last_chunk || held_count >= gcdrb_pkg::MAX_CHUNKS)
            begin
                place_batch();
            end
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (placement_q.size() == 0)
            begin
                report("unexpected result, chunk_index", -1, int'(result_ch.chunk_index));
            end
            else
            begin
                e = placement_q.pop_front();
                if (result_ch.chunk_index !== e.idx)
                begin
                    report("chunk_index", int'(e.idx), int'(result_ch.chunk_index));
                end
                if (result_ch.assigned_domain !== e.dom)
                begin
                    report("assigned_domain", int'(e.dom), int'(result_ch.assigned_domain));
                end
                if (result_ch.assigned_rank !== e.rnk)
                begin
                    report("assigned_rank", int'(e.rnk), int'(result_ch.assigned_rank));
                end
                if (result_ch.over_target !== e.over)
                begin
                    report("over_target", int'(e.over), int'(result_ch.over_target));
                end
                if (result_ch.last_result !== e.last)
                begin
                    report("last_result", int'(e.last), int'(result_ch.last_result));
                end
            end
        end
    end

    // chunk driver
    always @(negedge clk)
    begin
        chunk_t c;
        if (rst_n)
        begin
            if (chunk_ch.valid && !in_taken)
            begin
                // hold until taken
            end
            else if (send_gap > 0)
            begin
                chunk_ch.valid <= 1'b0;
                send_gap--;
            end
            else if (chunk_q.size() > 0)
            begin
                c = chunk_q.pop_front();
                chunk_ch.element_count <= c.elems;
                chunk_ch.wanted_domain <= c.dom;
                chunk_ch.wanted_rank <= c.rnk;
                chunk_ch.last_chunk <= c.last;
                chunk_ch.valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
            begin
                chunk_ch.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_gap > 0)
            begin
                result_ch.ready <= 1'b0;
                ready_gap--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                ready_gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic add_chunk(input logic [gcdrb_pkg::ELEM_W-1:0] el, input int wd,
                             input int wr, input bit last);
        chunk_t c;
        c.elems = el;
        c.dom = wd[gcdrb_pkg::REQ_W-1:0];
        c.rnk = wr[gcdrb_pkg::REQ_W-1:0];
        c.last = last;
        chunk_q.insert(chunk_q.size(), c);
    endtask

    task automatic wait_drained();
        while (!(chunk_q.size() == 0 && !chunk_ch.valid && placement_q.size() == 0
                 && held_count == 0))
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [0:0] idx, input logic [gcdrb_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == gcdrb_pkg::REG_TARGET)
        begin
            shadow_target = val;
        end
        else
        begin
            shadow_ranks = val;
        end
    endtask

    task automatic set_phase(input logic [gcdrb_pkg::CFG_W-1:0] tgt,
                             input logic [gcdrb_pkg::CFG_W-1:0] nr);
        wait_drained();
        write_cfg(gcdrb_pkg::REG_TARGET, tgt);
        write_cfg(gcdrb_pkg::REG_RANKS, nr);
    endtask

    function automatic logic [gcdrb_pkg::ELEM_W-1:0] rand_elems();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 3);
            3: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_req(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return -1;
        end
        if (r == 3)
        begin
            return -int'($urandom_range(1, 64));
        end
        if (r == 4)
        begin
            return 63;
        end
        return $urandom_range(0, span - 1);
    endfunction

    task automatic rand_batch(input int size);
        int dspan;
        int rspan;
        dspan = $urandom_range(1, 3) == 1 ? 64 : $urandom_range(1, 8);
        rspan = $urandom_range(1, 3) == 1 ? 64 : $urandom_range(1, 8);
        for (int k = 0; k < size; k++)
        begin
            add_chunk(rand_elems(), rand_req(dspan), rand_req(rspan),
                      (k == size - 1)
                      && (size < gcdrb_pkg::MAX_CHUNKS || $urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int sent;
        int size;
        logic [gcdrb_pkg::CFG_W-1:0] t;
        logic [gcdrb_pkg::CFG_W-1:0] r;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        chunk_ch.valid = 1'b0;
        chunk_ch.element_count = '0;
        chunk_ch.wanted_domain = '0;
        chunk_ch.wanted_rank = '0;
        chunk_ch.last_chunk = 1'b0;
        result_ch.ready = 1'b0;
        errors = 0;
        send_gap = 0;
        ready_gap = 0;
        quiet = 0;
        held_count = 0;
        shadow_target = 7'd1;
        shadow_ranks = 7'd1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset: one domain, one rank
        add_chunk('1, -1, -1, 1);
        add_chunk(32'd0, 63, 63, 0);
        add_chunk(32'd5, -64, -1, 1);
        set_phase(7'd64, 7'd64);
        // ties on zero loads, fixed ranks at the top
        add_chunk(32'd0, -1, -1, 0);
        add_chunk(32'd0, -1, 63, 0);
        add_chunk('1, 0, 0, 0);
        add_chunk('1, 63, -1, 1);
        set_phase(7'd2, 7'd3);
        // more named domains than the target; rank request beyond the count
        add_chunk(32'd10, 1, 5, 0);
        add_chunk(32'd20, 2, -1, 0);
        add_chunk(32'd30, 3, 2, 0);
        add_chunk(32'd7, -1, -1, 1);
        set_phase(7'd0, 7'd127);
        add_chunk(32'd1, -1, 1, 0);
        add_chunk(32'd2, -1, -1, 1);
        set_phase(7'd127, 7'd0);
        add_chunk(32'd3, -1, -1, 0);
        add_chunk(32'd3, -1, -1, 1);
        // full batch; last_chunk on its final chunk is set at random
        set_phase(7'd4, 7'd3);
        rand_batch(gcdrb_pkg::MAX_CHUNKS);

        sent = 0;
        while (sent < 240)
        begin
            case ($urandom_range(0, 5))
                0: begin t = 7'd1; r = 7'd1; end
                1: begin t = 7'd64; r = 7'd64; end
                2: begin t = 7'd0; r = 7'd127; end
                default:
                begin
                    t = gcdrb_pkg::CFG_W'($urandom_range(0, 127));
                    r = gcdrb_pkg::CFG_W'($urandom_range(0, 127));
                end
            endcase
            if ($urandom_range(0, 1))
            begin
                t = gcdrb_pkg::CFG_W'($urandom_range(1, 8));
                r = gcdrb_pkg::CFG_W'($urandom_range(1, 8));
            end
            set_phase(t, r);
            quiet = ($urandom_range(0, 3) == 0);
            for (int b = 0; b < 4; b++)
            begin
                size = (sent == 160) ? gcdrb_pkg::MAX_CHUNKS : $urandom_range(1, 10);
                rand_batch(size);
                sent += size;
            end
            quiet = 0;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
